@@ src/i2rs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the digit-to-ASCII function for the integer to radix string block.
// No dependencies.
package i2rs_pkg;

    localparam int RADIX_W  = 8;
    localparam int CAP_W    = 16;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int DIGIT_W  = 6;
    localparam int OUT_W    = 16;
    localparam int DIV_BITS = 4;
    localparam int MAX_RESULTS = 31;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd35;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_Z    = 8'h5A;

    // Classified command header passed from the front end to the back end
    typedef struct packed {
        logic               err;
        logic [DIGIT_W-1:0] radix;
        logic [CAP_W-1:0]   capacity;
    } cmd_hdr_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } div_res_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dc;
        begin
            dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
            if (dc < 6'd10)
            begin
                digit_char = CHAR_ZERO + CHAR_W'(dc);
            end
            else
            begin
                digit_char = CHAR_A + CHAR_W'(dc) - 8'd10;
            end
        end
    endfunction

endpackage

@@ src/i2rs_front.sv @@
`timescale 1ns / 1ps
// Input stage: accepts a transaction, flags sign and radix errors, registers the command.
// Depends on i2rs_pkg.
module i2rs_front
    import i2rs_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [VALUE_BITS-1:0]   value,
    input  logic [RADIX_W-1:0]      radix,
    input  logic [CAP_W-1:0]        capacity,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output cmd_hdr_t                cmd_hdr,
    output logic [VALUE_BITS-2:0]   cmd_mag
);

    logic                  valid_reg;
    cmd_hdr_t              hdr_reg;
    logic [VALUE_BITS-2:0] mag_reg;
    logic                  bad;

    assign in_ready = !valid_reg || cmd_ready;
    assign bad = value[VALUE_BITS-1] || (radix < RADIX_MIN) || (radix > RADIX_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hdr_reg.err      <= bad;
            hdr_reg.radix    <= radix[DIGIT_W-1:0];
            hdr_reg.capacity <= capacity;
            mag_reg          <= value[VALUE_BITS-2:0];
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd_hdr   = hdr_reg;
    assign cmd_mag   = mag_reg;

endmodule

@@ src/i2rs_queue.sv @@
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the conversion sequencer.
// Depends on i2rs_pkg.
module i2rs_queue
    import i2rs_pkg::*;
#(
    parameter int WIDTH = 54
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/i2rs_div.sv @@
`timescale 1ns / 1ps
// Iterative divider by a small radix: four quotient bits per cycle, remainder below 64.
// Depends on i2rs_pkg.
module i2rs_div
    import i2rs_pkg::*;
#(
    parameter int MAG_W = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MAG_W-1:0]   dividend,
    input  logic [DIGIT_W-1:0] radix,
    output div_res_t           res,
    output logic [MAG_W-1:0]   quotient
);

    localparam int PAD_W = ((MAG_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int STEPS = PAD_W / DIV_BITS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PAD_W-1:0]   work_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [DIGIT_W-1:0] radix_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIGIT_W:0]    trial [DIV_BITS];
    logic [DIGIT_W-1:0]  part  [DIV_BITS+1];
    logic [DIV_BITS-1:0] qbits;

    // Restoring division, one quotient bit per unrolled step
    always_comb
    begin
        part[0] = rem_reg;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            trial[j] = {part[j], work_reg[PAD_W-1-j]};
            if (trial[j] >= {1'b0, radix_reg})
            begin
                part[j+1]           = DIGIT_W'(trial[j] - {1'b0, radix_reg});
                qbits[DIV_BITS-1-j] = 1'b1;
            end
            else
            begin
                part[j+1]           = trial[j][DIGIT_W-1:0];
                qbits[DIV_BITS-1-j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg  <= PAD_W'(dividend);
            rem_reg   <= '0;
            radix_reg <= radix;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[PAD_W-DIV_BITS-1:0], qbits};
            rem_reg  <= part[DIV_BITS];
        end
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;
    assign quotient = work_reg[MAG_W-1:0];

endmodule

@@ src/i2rs_back.sv @@
`timescale 1ns / 1ps
// Conversion sequencer: drives the divider, stores digits, emits characters most significant first.
// Depends on i2rs_pkg and i2rs_div.
module i2rs_back
    import i2rs_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_hdr_t              cmd_hdr,
    input  logic [VALUE_BITS-2:0] cmd_mag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      out_data,
    output logic                  out_last,
    output logic                  out_status
);

    localparam int MAG_W = VALUE_BITS - 1;
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int LIMIT = (MAX_DIGITS < MAX_RESULTS) ? MAX_DIGITS : MAX_RESULTS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_OUT  = 5'b01000,
        S_ERR  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [DIGIT_W-1:0] radix_reg, radix_next;

    logic [DIGIT_W-1:0] store_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    div_res_t           div_res;
    logic [MAG_W-1:0]   div_quot;
    logic               div_start;
    logic [MAG_W-1:0]   div_dividend;
    logic [DIGIT_W-1:0] div_radix;
    logic               wr_en;
    logic [COUNT_W:0]   cnt_inc;

    i2rs_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (div_radix),
        .res      (div_res),
        .quotient (div_quot)
    );

    assign cnt_inc   = {1'b0, count_reg} + 1'b1;
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        rd_idx_next  = rd_idx_reg;
        cap_next     = cap_reg;
        radix_next   = radix_reg;
        div_start    = 1'b0;
        div_dividend = cmd_mag;
        div_radix    = cmd_hdr.radix;
        wr_en        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_hdr.err)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        count_next = '0;
                        cap_next   = cmd_hdr.capacity;
                        radix_next = cmd_hdr.radix;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    wr_en = 1'b1;
                    if (div_quot == '0)
                    begin
                        if (CAP_W'(cnt_inc) > cap_reg)
                        begin
                            state_next = S_ERR;
                        end
                        else
                        begin
                            total_next  = COUNT_W'(cnt_inc);
                            rd_idx_next = IDX_W'(count_reg);
                            state_next  = S_RD;
                        end
                    end
                    else if (cnt_inc >= (COUNT_W+1)'(LIMIT))
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        // The command has left the queue; divide by the held radix
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                        div_radix    = radix_reg;
                        count_next   = COUNT_W'(cnt_inc);
                    end
                end
            end
            S_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (rd_idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            S_ERR:
            begin
                total_next = '0;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            rd_idx_reg <= '0;
            cap_reg    <= '0;
            radix_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            rd_idx_reg <= rd_idx_next;
            cap_reg    <= cap_next;
            radix_reg  <= radix_next;
        end
    end

    // Digit store: written once per division, read one entry per character
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[IDX_W'(count_reg)] <= div_res.rem;
        end
        rd_data_reg <= store_mem[rd_idx_reg];
    end

    always_comb
    begin
        out_valid  = (state_reg == S_OUT) || (state_reg == S_ERR);
        out_status = (state_reg == S_ERR);
        if (state_reg == S_ERR)
        begin
            out_data = '0;
            out_last = 1'b1;
        end
        else
        begin
            out_data = {(OUT_W-CHAR_W-COUNT_W)'(0), total_reg, digit_char(rd_data_reg)};
            out_last = (rd_idx_reg == '0);
        end
    end

endmodule

@@ src/integer_to_radix_string.sv @@
`timescale 1ns / 1ps
// Integer to ASCII string conversion in radix 2..36, most significant character first.
// Path: the input stage registers the command and the two-entry queue holds it; then per digit
// one division in the single shared divider, then per character the digit store read (S_RD) and
// output (S_OUT) states. The sequencer takes a new command only when idle, after the last is out.
// Reset: rst_n is asynchronous, active low; clears all handshake and sequencer state.
module integer_to_radix_string
    import i2rs_pkg::*;
#(
    parameter int MAX_DIGITS = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // value [VALUE_BITS-1:0], radix [+8], capacity [+16], zero pad to whole bytes
    input  logic [((VALUE_BITS+RADIX_W+CAP_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // character [7:0], digit_count [12:8], zero pad [15:13]
    output logic [OUT_W-1:0]    m_axis_tdata,
    output logic                m_axis_tlast,
    // status [0]: 0 ok, 1 range error
    output logic                m_axis_tuser
);

    localparam int HDR_W = $bits(cmd_hdr_t);
    localparam int Q_W   = HDR_W + VALUE_BITS - 1;

    logic                  fe_valid;
    logic                  fe_ready;
    cmd_hdr_t              fe_hdr;
    logic [VALUE_BITS-2:0] fe_mag;
    logic                  q_valid;
    logic                  q_ready;
    logic [Q_W-1:0]        q_data;
    cmd_hdr_t              be_hdr;
    logic [VALUE_BITS-2:0] be_mag;

    // Front: take a transaction and flag sign or radix errors up front
    i2rs_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .value     (s_axis_tdata[VALUE_BITS-1:0]),
        .radix     (s_axis_tdata[VALUE_BITS +: RADIX_W]),
        .capacity  (s_axis_tdata[VALUE_BITS+RADIX_W +: CAP_W]),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd_hdr   (fe_hdr),
        .cmd_mag   (fe_mag)
    );

    // Queue: lets the front keep accepting while a conversion is running
    i2rs_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  ({fe_hdr, fe_mag}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign be_hdr = q_data[Q_W-1 -: HDR_W];
    assign be_mag = q_data[VALUE_BITS-2:0];

    // Back: repeated division, digit store, character emission
    i2rs_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd_hdr    (be_hdr),
        .cmd_mag    (be_mag),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_status (m_axis_tuser)
    );

endmodule

@@ src/i2rs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the result stream, bound to the top level.
// Depends on i2rs_pkg and integer_to_radix_string.
module i2rs_checker
    import i2rs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast,
    input logic             m_axis_tuser
);

    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] cnt;

    assign ch  = m_axis_tdata[CHAR_W-1:0];
    assign cnt = m_axis_tdata[CHAR_W +: COUNT_W];

    // Hold a stalled transaction unchanged
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (ch == '0) && (cnt == '0))
        else $error("malformed range-error result");

    a_ok_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (cnt != '0) && (((ch >= CHAR_ZERO) && (ch <= 8'h39))
            || ((ch >= CHAR_A) && (ch <= CHAR_Z))))
        else $error("bad digit character or count");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser && (cnt == 5'd1) |-> m_axis_tlast)
        else $error("single-digit string not marked last");

endmodule

bind integer_to_radix_string i2rs_checker u_i2rs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
